@@ src/atgs_pkg.sv @@
// Types and constants for the author-topic Gibbs sampler.
// No dependencies.
package atgs_pkg;

	localparam int TOPIC_W = 6;
	localparam int NWORD_W = 12;
	localparam int OWORD_W = 10;
	localparam int AUTH_W  = 6;
	localparam int CNT_W   = 24;
	localparam int DIV_W   = 46;
	localparam int SUM_W   = 38;
	localparam int CUM_W   = 48;
	localparam int RS_W    = 54;
	localparam int CLR_W   = 22;
	localparam int TEFF_W  = 7;
	localparam logic [TEFF_W-1:0] TOPICS_MAX = 7'd64;

	localparam logic [31:0] ALPHA_RST  = 32'd3276800;
	localparam logic [31:0] BETA_RST   = 32'd655;
	localparam logic [6:0]  TOPICS_RST = 7'd64;
	localparam logic [12:0] NVOC_RST   = 13'd4096;
	localparam logic [10:0] OVOC_RST   = 11'd1024;

	typedef enum logic [2:0] {
		CFG_ALPHA  = 3'd0,
		CFG_BETA   = 3'd1,
		CFG_TOPICS = 3'd2,
		CFG_NVOC   = 3'd3,
		CFG_OVOC   = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_UPD_RD,
		S_UPD_WR,
		S_T_RD,
		S_T_LOAD,
		S_DIV,
		S_MUL,
		S_ACC,
		S_RS,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_OUT
	} state_t;

	typedef enum logic {
		OP_ADD      = 1'b0,
		OP_RESAMPLE = 1'b1
	} op_t;

endpackage

@@ src/author_topic_gibbs_sampler_top.sv @@
// Author-topic Gibbs sampler: count tables, shared restoring divider, sequencer.
// Depends on atgs_pkg.
// An add item only updates the count tables; a resample runs every topic in use (T topics)
// through the one bit-serial divider, which forms both quotients of every topic.
// One item at a time; a new item is taken once the previous result is registered.
// Reset: asynchronous, active low; afterwards a clearing pass over every address zeroes
// the count tables, during which no item is taken (configuration writes are).
module author_topic_gibbs_sampler_top
	import atgs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// word_index[11:0], author_index[17:12], topic[23:18], random_fraction[39:24]
	input  logic [39:0] s_axis_tdata,
	// operation[0], word_kind[1]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// new_topic[5:0], zero fill above
	output logic [7:0]  m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	state_t state_q, state_d;

	logic [31:0] alpha_q, beta_q;
	logic [6:0]  topics_q;
	logic [12:0] nvoc_q;
	logic [10:0] ovoc_q;

	logic [CLR_W-1:0]   clr_q;
	logic               opin_q, up_q;
	logic [NWORD_W-1:0] word_q;
	logic [AUTH_W-1:0]  auth_q;
	logic [TOPIC_W-1:0] cur_topic_q;
	logic [15:0]        rnd_q;
	logic [TEFF_W-1:0]  teff_q, t_q;
	logic [44:0]        vb_q;
	logic [38:0]        ta_q;
	logic [DIV_W-1:0]   aden_q;
	logic [CNT_W-1:0]   ac_q;
	logic [SUM_W-1:0]   sum_q;
	logic [RS_W-1:0]    rs_q;
	logic [31:0]        q1_q;
	logic [63:0]        prod_q;
	logic               m_valid_q;
	logic [TOPIC_W-1:0] m_topic_q;

	logic [DIV_W-1:0] div_rem_q, div_den_q;
	logic [31:0]      div_quo_q;
	logic [4:0]       div_cnt_q;
	logic             div_sat_q, div_sel_q;

	// memories
	logic [CNT_W-1:0] nwt_mem  [0:(1<<18)-1];
	logic [CNT_W-1:0] at_mem   [0:(1<<12)-1];
	logic [CNT_W-1:0] tnt_mem  [0:(1<<6)-1];
	logic [CNT_W-1:0] aut_mem  [0:(1<<6)-1];
	logic [CNT_W-1:0] aowt_mem [0:(1<<22)-1];
	logic [CNT_W-1:0] aott_mem [0:(1<<12)-1];
	logic [CUM_W-1:0] cum_mem  [0:(1<<6)-1];

	logic [CNT_W-1:0] nwt_rd, at_rd, tnt_rd, aut_rd, aowt_rd, aott_rd;
	logic [CUM_W-1:0] cum_rd;

	logic [17:0] nwt_addr;
	logic [11:0] at_addr, aott_addr;
	logic [5:0]  tnt_addr, aut_addr;
	logic [21:0] aowt_addr;
	logic        nwt_we, at_we, tnt_we, aut_we, aowt_we, aott_we, cum_we;
	logic [CNT_W-1:0] nwt_wd, at_wd, tnt_wd, aut_wd, aowt_wd, aott_wd;
	logic [SUM_W-1:0] sum_new;

	logic [TOPIC_W-1:0] tsel;
	logic               accept, out_free, last_t, div_done, div_ge;
	logic [DIV_W:0]     div_rem2;
	logic [31:0]        div_res;
	logic [CNT_W-1:0]   wc, tt;
	logic [DIV_W-1:0]   num1, den1, num2;
	logic [TEFF_W-1:0]  teff_in;

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c, input logic up);
		logic [CNT_W-1:0] r;
		r = c;
		if (up) begin
			if (c != '1) r = c + 1'b1;
		end else begin
			if (c != '0) r = c - 1'b1;
		end
		return r;
	endfunction

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, m_topic_q};
	assign last_t        = ((t_q + 1'b1) == teff_q);

	assign teff_in = (topics_q == '0) ? 7'd1 :
		(topics_q > TOPICS_MAX) ? TOPICS_MAX : topics_q;

	assign tsel = (state_q == S_UPD_RD || state_q == S_UPD_WR) ? cur_topic_q : t_q[TOPIC_W-1:0];

	assign wc   = opin_q ? aowt_rd : nwt_rd;
	assign tt   = opin_q ? aott_rd : tnt_rd;
	assign num1 = {6'd0, wc, 16'd0} + {14'd0, beta_q};
	assign den1 = {6'd0, tt, 16'd0} + {1'b0, vb_q};
	assign num2 = {6'd0, ac_q, 16'd0} + {14'd0, alpha_q};

	assign div_rem2 = {div_rem_q, 1'b0};
	assign div_ge   = (div_rem2 >= {1'b0, div_den_q});
	assign div_done = div_sat_q || (div_cnt_q == 5'd31);
	assign div_res  = div_sat_q ? 32'hFFFF_FFFF : {div_quo_q[30:0], div_ge};
	assign sum_new  = sum_q + {6'd0, prod_q[63:32]};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:    if (clr_q == '1) state_d = S_IDLE;
			S_IDLE:     if (accept) state_d = S_UPD_RD;
			S_UPD_RD:   state_d = S_UPD_WR;
			S_UPD_WR:   state_d = up_q ? S_OUT : S_T_RD;
			S_T_RD:     state_d = S_T_LOAD;
			S_T_LOAD:   state_d = S_DIV;
			S_DIV:      if (div_done && div_sel_q) state_d = S_MUL;
			S_MUL:      state_d = S_ACC;
			S_ACC:      state_d = last_t ? S_RS : S_T_RD;
			S_RS:       state_d = S_SRCH_RD;
			S_SRCH_RD:  state_d = S_SRCH_CMP;
			S_SRCH_CMP: begin
				if (({cum_rd[SUM_W-1:0], 16'd0} >= rs_q) || last_t) state_d = S_UPD_RD;
				else state_d = S_SRCH_RD;
			end
			S_OUT:      if (out_free) state_d = S_IDLE;
			default:    state_d = S_CLEAR;
		endcase
	end

	// memory controls
	always_comb begin
		nwt_addr  = {word_q, tsel};
		at_addr   = {auth_q, tsel};
		tnt_addr  = tsel;
		aut_addr  = auth_q;
		aowt_addr = {auth_q, word_q[OWORD_W-1:0], tsel};
		aott_addr = {auth_q, tsel};
		nwt_wd    = bump(nwt_rd, up_q);
		at_wd     = bump(at_rd, up_q);
		tnt_wd    = bump(tnt_rd, up_q);
		aut_wd    = bump(aut_rd, up_q);
		aowt_wd   = bump(aowt_rd, up_q);
		aott_wd   = bump(aott_rd, up_q);
		nwt_we    = 1'b0;
		at_we     = 1'b0;
		tnt_we    = 1'b0;
		aut_we    = 1'b0;
		aowt_we   = 1'b0;
		aott_we   = 1'b0;
		cum_we    = (state_q == S_ACC);
		unique case (state_q)
			S_CLEAR: begin
				nwt_addr  = clr_q[17:0];
				at_addr   = clr_q[11:0];
				tnt_addr  = clr_q[5:0];
				aut_addr  = clr_q[5:0];
				aowt_addr = clr_q;
				aott_addr = clr_q[11:0];
				nwt_wd    = '0;
				at_wd     = '0;
				tnt_wd    = '0;
				aut_wd    = '0;
				aowt_wd   = '0;
				aott_wd   = '0;
				nwt_we    = 1'b1;
				at_we     = 1'b1;
				tnt_we    = 1'b1;
				aut_we    = 1'b1;
				aowt_we   = 1'b1;
				aott_we   = 1'b1;
			end
			S_UPD_WR: begin
				nwt_we  = !opin_q;
				tnt_we  = !opin_q;
				aowt_we = opin_q;
				aott_we = opin_q;
				at_we   = 1'b1;
				aut_we  = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (nwt_we) nwt_mem[nwt_addr] <= nwt_wd;
		nwt_rd <= nwt_mem[nwt_addr];
	end

	always_ff @(posedge clk) begin
		if (at_we) at_mem[at_addr] <= at_wd;
		at_rd <= at_mem[at_addr];
	end

	always_ff @(posedge clk) begin
		if (tnt_we) tnt_mem[tnt_addr] <= tnt_wd;
		tnt_rd <= tnt_mem[tnt_addr];
	end

	always_ff @(posedge clk) begin
		if (aut_we) aut_mem[aut_addr] <= aut_wd;
		aut_rd <= aut_mem[aut_addr];
	end

	always_ff @(posedge clk) begin
		if (aowt_we) aowt_mem[aowt_addr] <= aowt_wd;
		aowt_rd <= aowt_mem[aowt_addr];
	end

	always_ff @(posedge clk) begin
		if (aott_we) aott_mem[aott_addr] <= aott_wd;
		aott_rd <= aott_mem[aott_addr];
	end

	always_ff @(posedge clk) begin
		if (cum_we) cum_mem[t_q[TOPIC_W-1:0]] <= {{(CUM_W-SUM_W){1'b0}}, sum_new};
		cum_rd <= cum_mem[t_q[TOPIC_W-1:0]];
	end

	// control and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			m_valid_q <= 1'b0;
			alpha_q   <= ALPHA_RST;
			beta_q    <= BETA_RST;
			topics_q  <= TOPICS_RST;
			nvoc_q    <= NVOC_RST;
			ovoc_q    <= OVOC_RST;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == S_OUT && out_free) m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ALPHA:  alpha_q  <= cfg_data;
					CFG_BETA:   beta_q   <= cfg_data;
					CFG_TOPICS: topics_q <= cfg_data[6:0];
					CFG_NVOC:   nvoc_q   <= cfg_data[12:0];
					CFG_OVOC:   ovoc_q   <= cfg_data[10:0];
					default: ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					word_q      <= s_axis_tdata[11:0];
					auth_q      <= s_axis_tdata[17:12];
					cur_topic_q <= s_axis_tdata[23:18];
					rnd_q       <= s_axis_tdata[39:24];
					up_q        <= (s_axis_tuser[0] == OP_ADD);
					opin_q      <= s_axis_tuser[1];
					teff_q      <= teff_in;
					ta_q        <= teff_in * alpha_q;
					vb_q        <= (s_axis_tuser[1] ? {2'b00, ovoc_q} : nvoc_q) * beta_q;
				end
			end
			S_UPD_WR: begin
				aden_q <= {6'd0, bump(aut_rd, up_q), 16'd0} + {7'd0, ta_q};
				t_q    <= '0;
				sum_q  <= '0;
			end
			S_T_LOAD: begin
				ac_q      <= at_rd;
				div_rem_q <= num1;
				div_den_q <= den1;
				div_sat_q <= (num1 >= den1);
				div_quo_q <= '0;
				div_cnt_q <= '0;
				div_sel_q <= 1'b0;
			end
			S_DIV: begin
				if (div_done) begin
					if (!div_sel_q) begin
						q1_q      <= div_res;
						div_rem_q <= num2;
						div_den_q <= aden_q;
						div_sat_q <= (num2 >= aden_q);
						div_quo_q <= '0;
						div_cnt_q <= '0;
						div_sel_q <= 1'b1;
					end else begin
						div_quo_q <= div_res;
					end
				end else begin
					div_rem_q <= div_ge ? div_rem2[DIV_W-1:0] - div_den_q : div_rem2[DIV_W-1:0];
					div_quo_q <= {div_quo_q[30:0], div_ge};
					div_cnt_q <= div_cnt_q + 1'b1;
				end
			end
			S_MUL: prod_q <= q1_q * div_quo_q;
			S_ACC: begin
				sum_q <= sum_new;
				if (!last_t) t_q <= t_q + 1'b1;
			end
			S_RS: begin
				rs_q <= rnd_q * sum_q;
				t_q  <= '0;
			end
			S_SRCH_CMP: begin
				if ({cum_rd[SUM_W-1:0], 16'd0} >= rs_q) begin
					cur_topic_q <= t_q[TOPIC_W-1:0];
					up_q        <= 1'b1;
				end else if (last_t) begin
					cur_topic_q <= '0;
					up_q        <= 1'b1;
				end else begin
					t_q <= t_q + 1'b1;
				end
			end
			S_OUT: if (out_free) m_topic_q <= cur_topic_q;
			default: ;
		endcase
	end

endmodule
